### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sps_pkg.sv
// Shared types, codes and tables for the stepper phase sequencer.
// No dependencies.
package sps_pkg;

	localparam int PORTS_DEF  = 2;
	localparam int MICROSTEPS = 16;
	localparam int PHASE_W    = 6;	// 4 * MICROSTEPS entries
	localparam int IDX_W      = 4;	// index within a quarter
	localparam int DUTY_W     = 12;
	localparam int TIME_W     = 32;
	localparam int STEPS_W    = 32;
	localparam int IVAL_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PHASE_W-1:0] EIGHTH_INC = PHASE_W'(MICROSTEPS / 2);
	localparam logic [PHASE_W-1:0] FULL_STEP  = PHASE_W'(MICROSTEPS);
	localparam logic [PHASE_W-1:0] MICRO_INC  = PHASE_W'(1);
	localparam logic [DUTY_W-1:0]  DUTY_FULL  = DUTY_W'(4095);

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_DETACHED    = 2'd1;
	localparam logic [1:0] ST_NO_INTERVAL = 2'd2;

	// step styles
	localparam logic [1:0] STY_SINGLE     = 2'd0;
	localparam logic [1:0] STY_DOUBLE     = 2'd1;
	localparam logic [1:0] STY_INTERLEAVE = 2'd2;
	localparam logic [1:0] STY_MICRO      = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IVAL0  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IVAL1  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACH = 2'd2;

	// bridge patterns per quadrant in microstep mode
	localparam logic [3:0] QUAD_BITS0 = 4'h3;
	localparam logic [3:0] QUAD_BITS1 = 4'h6;
	localparam logic [3:0] QUAD_BITS2 = 4'hC;
	localparam logic [3:0] QUAD_BITS3 = 4'h9;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
		logic [3:0]        coil_bits;
	} drive_t;

	// Duty for sine point i: (amp * 4095 + 127) / 255 with amp from the quarter-wave
	// table 0 25 50 74 98 120 142 162 180 197 212 225 236 244 250 254 255.
	function automatic logic [DUTY_W-1:0] sine_duty(input logic [IDX_W:0] i);
		logic [DUTY_W-1:0] d;
		case (i)
			5'd0:    d = 12'd0;
			5'd1:    d = 12'd401;
			5'd2:    d = 12'd803;
			5'd3:    d = 12'd1188;
			5'd4:    d = 12'd1574;
			5'd5:    d = 12'd1927;
			5'd6:    d = 12'd2280;
			5'd7:    d = 12'd2602;
			5'd8:    d = 12'd2891;
			5'd9:    d = 12'd3164;
			5'd10:   d = 12'd3404;
			5'd11:   d = 12'd3613;
			5'd12:   d = 12'd3790;
			5'd13:   d = 12'd3918;
			5'd14:   d = 12'd4015;
			5'd15:   d = 12'd4079;
			5'd16:   d = 12'd4095;
			default: d = 12'd4095;
		endcase
		return d;
	endfunction

	// Full/half step bridge pattern per eighth of the electrical cycle
	function automatic logic [3:0] full_bits(input logic [2:0] oct);
		logic [3:0] b;
		case (oct)
			3'd0:    b = 4'h1;
			3'd1:    b = 4'h3;
			3'd2:    b = 4'h2;
			3'd3:    b = 4'h6;
			3'd4:    b = 4'h4;
			3'd5:    b = 4'hC;
			3'd6:    b = 4'h8;
			3'd7:    b = 4'h9;
			default: b = 4'h1;
		endcase
		return b;
	endfunction

endpackage

### rtl/stepper_phase_sequencer.sv
// Stepper phase sequencer: an accepted transaction sits in the request register, moves
// to the result register once that is empty or being taken, and is presented from there.
// Throughput is one transaction per cycle; a result left waiting holds the request
// register and so stalls the input until it is taken.
// Reset (arst_n, asynchronous) clears all port state and configuration at once;
// no clearing pass.
module stepper_phase_sequencer #(
	parameter int PORTS = sps_pkg::PORTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic                             port,
	input  logic [sps_pkg::TIME_W-1:0]       now_ms,
	input  logic [sps_pkg::STEPS_W-1:0]      step_count,
	input  logic                             direction,
	input  logic [1:0]                       step_style,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             stepped,
	output logic                             step_port,
	output logic [sps_pkg::DUTY_W-1:0]       duty_a,
	output logic [sps_pkg::DUTY_W-1:0]       duty_b,
	output logic [3:0]                       coil_bits,
	output logic [sps_pkg::STEPS_W-1:0]      steps_remaining,
	output logic [1:0]                       cmd_status
);
	import sps_pkg::*;
`include "assert_macros.svh"

	localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

	// configuration
	logic [IVAL_W-1:0] ival_q [2];
	logic [1:0]        attach_q;

	// port state
	logic [PHASE_W-1:0] phase_q   [PORTS];
	logic               dir_q     [PORTS];
	logic [1:0]         style_q   [PORTS];
	logic               running_q [PORTS];
	logic [STEPS_W-1:0] steps_q   [PORTS];
	logic [TIME_W-1:0]  due_q     [PORTS];

	logic [PHASE_W-1:0] phase_nxt   [PORTS];
	logic               dir_nxt     [PORTS];
	logic [1:0]         style_nxt   [PORTS];
	logic               running_nxt [PORTS];
	logic [STEPS_W-1:0] steps_nxt   [PORTS];
	logic [TIME_W-1:0]  due_nxt     [PORTS];

	// request register
	logic               vld_s1;
	logic [1:0]         req_s1;
	logic               port_s1;
	logic [TIME_W-1:0]  now_s1;
	logic [STEPS_W-1:0] count_s1;
	logic               dir_s1;
	logic [1:0]         style_s1;

	// result register
	logic               vld_s2;
	logic               stepped_s2;
	logic               sport_s2;
	drive_t             drive_s2;
	logic [STEPS_W-1:0] rem_s2;
	logic [1:0]         status_s2;

	logic               advance;
	logic [TIME_W-1:0]  diff [PORTS];
	logic               found;
	logic [PIDX_W-1:0]  best;
	logic [TIME_W-1:0]  best_late;
	logic [PHASE_W-1:0] cd_phase_nxt;
	drive_t             cd_drive;

	logic               res_stepped;
	logic               res_sport;
	drive_t             res_drive;
	logic [STEPS_W-1:0] res_rem;
	logic [1:0]         res_status;

	logic               port_ok;
	logic [PIDX_W-1:0]  psel;
	logic [IVAL_W-1:0]  best_iv;
	logic [STEPS_W-1:0] best_steps;
	logic [TIME_W-1:0]  due_step;
	logic [TIME_W-1:0]  lag;

	assign cfg_ready = 1'b1;
	assign advance   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready  = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ival_q[0] <= '0;
			ival_q[1] <= '0;
			attach_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IVAL0:  ival_q[0] <= cfg_data;
				CFG_IVAL1:  ival_q[1] <= cfg_data;
				CFG_ATTACH: attach_q  <= cfg_data[1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1   <= req_type;
			port_s1  <= port;
			now_s1   <= now_ms;
			count_s1 <= step_count;
			dir_s1   <= direction;
			style_s1 <= step_style;
		end
	end

	// pick the most overdue running port, lower port wins a tie
	always_comb begin
		found     = 1'b0;
		best      = '0;
		best_late = '0;
		for (int p = 0; p < PORTS; p++) begin
			diff[p] = now_s1 - due_q[p];
			if (running_q[p] && !diff[p][TIME_W-1] && (!found || diff[p] > best_late)) begin
				found     = 1'b1;
				best      = PIDX_W'(p);
				best_late = diff[p];
			end
		end
	end

	sps_coil_drive u_coil_drive (
		.phase     (phase_q[best]),
		.style     (style_q[best]),
		.direction (dir_q[best]),
		.phase_nxt (cd_phase_nxt),
		.drive     (cd_drive)
	);

	assign port_ok    = 32'(port_s1) < PORTS;
	assign psel       = PIDX_W'(port_s1);
	assign best_iv    = ival_q[best];
	assign best_steps = (steps_q[best] != '0) ? steps_q[best] - 1'b1 : steps_q[best];
	assign due_step   = due_q[best] + TIME_W'(best_iv);
	assign lag        = now_s1 - due_step;

	always_comb begin
		for (int p = 0; p < PORTS; p++) begin
			phase_nxt[p]   = phase_q[p];
			dir_nxt[p]     = dir_q[p];
			style_nxt[p]   = style_q[p];
			running_nxt[p] = running_q[p];
			steps_nxt[p]   = steps_q[p];
			due_nxt[p]     = due_q[p];
		end
		res_stepped = 1'b0;
		res_sport   = 1'b0;
		res_drive   = '0;
		res_rem     = '0;
		res_status  = ST_OK;

		case (req_s1)
			REQ_TICK: begin
				// clock went back by more than an interval: resync to now
				for (int p = 0; p < PORTS; p++) begin
					if (running_q[p] && diff[p][TIME_W-1] &&
							((TIME_W'(0) - diff[p]) > TIME_W'(ival_q[p % 2]))) begin
						due_nxt[p] = now_s1;
					end
				end
				if (found) begin
					phase_nxt[best] = cd_phase_nxt;
					steps_nxt[best] = best_steps;
					res_stepped     = 1'b1;
					res_sport       = 1'(best);
					res_drive       = cd_drive;
					res_rem         = best_steps;
					if (best_steps == '0) begin
						running_nxt[best] = 1'b0;
					end else if (!lag[TIME_W-1] && lag > TIME_W'(best_iv)) begin
						due_nxt[best] = now_s1 + TIME_W'(best_iv);
					end else begin
						due_nxt[best] = due_step;
					end
				end
			end
			REQ_START: begin
				if (!port_ok || !attach_q[port_s1]) begin
					res_status = ST_DETACHED;
				end else if (ival_q[port_s1] == '0) begin
					res_status = ST_NO_INTERVAL;
				end else begin
					dir_nxt[psel]     = dir_s1;
					style_nxt[psel]   = style_s1;
					steps_nxt[psel]   = count_s1;
					running_nxt[psel] = count_s1 != '0;
					due_nxt[psel]     = now_s1;
				end
				if (port_ok) begin
					res_rem = steps_nxt[psel];
				end
			end
			REQ_STOP: begin
				if (!port_ok) begin
					res_status = ST_DETACHED;
				end else begin
					running_nxt[psel] = 1'b0;
					steps_nxt[psel]   = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PORTS; p++) begin
				phase_q[p]   <= '0;
				dir_q[p]     <= 1'b0;
				style_q[p]   <= STY_DOUBLE;
				running_q[p] <= 1'b0;
				steps_q[p]   <= '0;
				due_q[p]     <= '0;
			end
		end else if (advance) begin
			for (int p = 0; p < PORTS; p++) begin
				phase_q[p]   <= phase_nxt[p];
				dir_q[p]     <= dir_nxt[p];
				style_q[p]   <= style_nxt[p];
				running_q[p] <= running_nxt[p];
				steps_q[p]   <= steps_nxt[p];
				due_q[p]     <= due_nxt[p];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stepped_s2 <= res_stepped;
			sport_s2   <= res_sport;
			drive_s2   <= res_drive;
			rem_s2     <= res_rem;
			status_s2  <= res_status;
		end
	end

	assign out_valid       = vld_s2;
	assign stepped         = stepped_s2;
	assign step_port       = sport_s2;
	assign duty_a          = drive_s2.duty_a;
	assign duty_b          = drive_s2.duty_b;
	assign coil_bits       = drive_s2.coil_bits;
	assign steps_remaining = rem_s2;
	assign cmd_status      = status_s2;

	// a running port always has budget left
	for (genvar g = 0; g < PORTS; g++) begin : g_chk
		`ASSERT_CLK(a_run_budget, running_q[g] |-> (steps_q[g] != '0), "running port with no budget")
	end
	// a step always drives some bridge leg and reports ok
	`ASSERT_CLK(a_step_drive, (vld_s2 && stepped_s2) |-> (drive_s2.coil_bits != '0 && status_s2 == ST_OK), "step without drive")
	// an item moved into the result register is presented next cycle
	`ASSERT_ALWAYS(a_res_load, (arst_n && advance) |=> (!arst_n || vld_s2), "result lost")

endmodule

### rtl/sps_coil_drive.sv
// Phase advance and coil drive for one step of one port.
// Depends on sps_pkg.
module sps_coil_drive (
	input  logic [sps_pkg::PHASE_W-1:0] phase,
	input  logic [1:0]                  style,
	input  logic                        direction,
	output logic [sps_pkg::PHASE_W-1:0] phase_nxt,
	output sps_pkg::drive_t             drive
);
	import sps_pkg::*;

	logic [PHASE_W-1:0] delta;
	logic               odd;
	logic [IDX_W-1:0]   idx;
	logic [IDX_W:0]     cidx;
	logic [DUTY_W-1:0]  d_idx;
	logic [DUTY_W-1:0]  d_cidx;

	assign odd = phase[3];

	always_comb begin
		case (style)
			STY_SINGLE:     delta = odd ? EIGHTH_INC : FULL_STEP;
			STY_DOUBLE:     delta = odd ? FULL_STEP : EIGHTH_INC;
			STY_INTERLEAVE: delta = EIGHTH_INC;
			default:        delta = MICRO_INC;
		endcase
	end

	// wraps modulo the phase count in both directions
	assign phase_nxt = direction ? (phase - delta) : (phase + delta);

	assign idx    = phase_nxt[IDX_W-1:0];
	assign cidx   = (IDX_W+1)'(MICROSTEPS) - {1'b0, idx};
	assign d_idx  = sine_duty({1'b0, idx});
	assign d_cidx = sine_duty(cidx);

	always_comb begin
		drive.duty_a    = DUTY_FULL;
		drive.duty_b    = DUTY_FULL;
		drive.coil_bits = full_bits(phase_nxt[PHASE_W-1:PHASE_W-3]);
		if (style == STY_MICRO) begin
			// even quadrants: A falls from the peak, B rises
			if (phase_nxt[IDX_W] == 1'b0) begin
				drive.duty_a = d_cidx;
				drive.duty_b = d_idx;
			end else begin
				drive.duty_a = d_idx;
				drive.duty_b = d_cidx;
			end
			case (phase_nxt[PHASE_W-1:IDX_W])
				2'd0:    drive.coil_bits = QUAD_BITS0;
				2'd1:    drive.coil_bits = QUAD_BITS1;
				2'd2:    drive.coil_bits = QUAD_BITS2;
				default: drive.coil_bits = QUAD_BITS3;
			endcase
		end
	end

endmodule

### tb/sps_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the stepper phase sequencer testbench: request and result types and
// a class that predicts each result from its own copy of port state and registers.
// Depends on sps_pkg.
package sps_scoreboard_pkg;
	import sps_pkg::*;

	// codes the block defines no name for
	localparam logic [1:0]           REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic [7:0] SINE_AMP [17] = '{
		8'd0, 8'd25, 8'd50, 8'd74, 8'd98, 8'd120, 8'd142, 8'd162, 8'd180,
		8'd197, 8'd212, 8'd225, 8'd236, 8'd244, 8'd250, 8'd254, 8'd255
	};

	// bridge pattern per eighth of the electrical cycle, full and half step styles
	localparam logic [3:0] STEP_PATTERN [8] = '{
		4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
	};

	typedef struct {
		logic [1:0]         req;
		logic               port;
		logic [TIME_W-1:0]  now;
		logic [STEPS_W-1:0] steps;
		logic               dir;
		logic [1:0]         style;
	} step_req_t;

	typedef struct {
		logic               stepped;
		logic               sport;
		logic [DUTY_W-1:0]  duty_a;
		logic [DUTY_W-1:0]  duty_b;
		logic [3:0]         bits;
		logic [STEPS_W-1:0] rem;
		logic [1:0]         status;
	} step_result_t;

	function automatic logic [DUTY_W-1:0] duty_of(input logic [7:0] amp);
		return DUTY_W'((32'(amp) * 32'd4095 + 32'd127) / 32'd255);
	endfunction

	class step_scoreboard;
		bit [PHASE_W-1:0] phase [2];
		bit               dir [2];
		bit [1:0]         style [2];
		bit               running [2];
		bit [STEPS_W-1:0] budget [2];
		bit [TIME_W-1:0]  due [2];
		bit [IVAL_W-1:0]  ival [2];
		bit [1:0]         attach;

		step_result_t expected_q [$];
		int errors;
		int n_requests;
		int n_steps;
		int n_refused;
		int n_writes;

		function new();
			for (int p = 0; p < 2; p++) begin
				phase[p] = '0;
				dir[p] = 1'b0;
				style[p] = STY_DOUBLE;
				running[p] = 1'b0;
				budget[p] = '0;
				due[p] = '0;
				ival[p] = '0;
			end
			attach = '0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			n_writes++;
			case (idx)
				CFG_IVAL0:  ival[0] = data;
				CFG_IVAL1:  ival[1] = data;
				CFG_ATTACH: attach = data[1:0];
				default: ;
			endcase
		endfunction

		function void note_request(step_req_t r);
			step_result_t e;
			bit found;
			int best;
			bit [31:0] diff, best_late, lag, iv;
			bit [PHASE_W-1:0] ph, delta;
			bit [3:0] idx;
			bit [7:0] amp_a, amp_b;
			e = '{default: '0};
			found = 1'b0;
			best = 0;
			best_late = '0;
			n_requests++;
			case (r.req)
				REQ_TICK: begin
					for (int p = 0; p < 2; p++) begin
						if (running[p]) begin
							diff = r.now - due[p];
							if (diff[31]) begin
								// due time ahead: more than an interval means the clock went back
								if ((32'd0 - diff) > {16'b0, ival[p]})
									due[p] = r.now;
							end else if (!found || diff > best_late) begin
								found = 1'b1;
								best = p;
								best_late = diff;
							end
						end
					end
					if (found) begin
						iv = {16'b0, ival[best]};
						ph = phase[best];
						case (style[best])
							STY_SINGLE:     delta = ph[3] ? EIGHTH_INC : FULL_STEP;
							STY_DOUBLE:     delta = ph[3] ? FULL_STEP : EIGHTH_INC;
							STY_INTERLEAVE: delta = EIGHTH_INC;
							default:        delta = MICRO_INC;
						endcase
						ph = dir[best] ? ph - delta : ph + delta;
						phase[best] = ph;
						idx = ph[3:0];
						if (style[best] == STY_MICRO) begin
							// odd quadrants swap which coil rises
							if (!ph[4]) begin
								amp_a = SINE_AMP[16 - int'(idx)];
								amp_b = SINE_AMP[idx];
							end else begin
								amp_a = SINE_AMP[idx];
								amp_b = SINE_AMP[16 - int'(idx)];
							end
							case (ph[5:4])
								2'd0:    e.bits = QUAD_BITS0;
								2'd1:    e.bits = QUAD_BITS1;
								2'd2:    e.bits = QUAD_BITS2;
								default: e.bits = QUAD_BITS3;
							endcase
						end else begin
							amp_a = 8'd255;
							amp_b = 8'd255;
							e.bits = STEP_PATTERN[ph[5:3]];
						end
						e.stepped = 1'b1;
						e.sport = best[0];
						e.duty_a = duty_of(amp_a);
						e.duty_b = duty_of(amp_b);
						n_steps++;
						if (budget[best] != 0)
							budget[best]--;
						if (budget[best] == 0) begin
							running[best] = 1'b0;
						end else begin
							due[best] += iv;
							lag = r.now - due[best];
							if (!lag[31] && lag > iv)
								due[best] = r.now + iv;
						end
						e.rem = budget[best];
					end
				end
				REQ_START: begin
					if (!attach[r.port]) begin
						e.status = ST_DETACHED;
						n_refused++;
					end else if (ival[r.port] == 0) begin
						e.status = ST_NO_INTERVAL;
						n_refused++;
					end else begin
						dir[r.port] = r.dir;
						style[r.port] = r.style;
						budget[r.port] = r.steps;
						running[r.port] = (r.steps != 0);
						due[r.port] = r.now;
					end
					e.rem = budget[r.port];
				end
				REQ_STOP: begin
					running[r.port] = 1'b0;
					budget[r.port] = '0;
				end
				default: ;
			endcase
			expected_q.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (got_v !== want_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
			end
		endfunction

		function void check_result(step_result_t got);
			step_result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transaction, stepped %0h status %0h",
					$time, got.stepped, got.status);
				return;
			end
			e = expected_q.pop_front();
			compare_field("stepped", e.stepped, got.stepped);
			compare_field("step_port", e.sport, got.sport);
			compare_field("duty_a", e.duty_a, got.duty_a);
			compare_field("duty_b", e.duty_b, got.duty_b);
			compare_field("coil_bits", e.bits, got.bits);
			compare_field("steps_remaining", e.rem, got.rem);
			compare_field("cmd_status", e.status, got.status);
		endfunction
	endclass

endpackage

### tb/tb_stepper_phase_sequencer.sv
`timescale 1ns / 100ps
// Top of the stepper phase sequencer testbench: clock, reset, request and register
// drivers, result monitor and watchdog. Depends on sps_pkg and sps_scoreboard_pkg.
module tb_stepper_phase_sequencer;
	import sps_pkg::*;
	import sps_scoreboard_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 135;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            req_type = '0;
	logic                  port = 1'b0;
	logic [TIME_W-1:0]     now_ms = '0;
	logic [STEPS_W-1:0]    step_count = '0;
	logic                  direction = 1'b0;
	logic [1:0]            step_style = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  stepped;
	logic                  step_port;
	logic [DUTY_W-1:0]     duty_a;
	logic [DUTY_W-1:0]     duty_b;
	logic [3:0]            coil_bits;
	logic [STEPS_W-1:0]    steps_remaining;
	logic [1:0]            cmd_status;

	int             snd_idle = 28;
	int             rcv_idle = 58;
	int             stall_cycles = 0;
	bit [31:0]      cur_ms = '0;
	step_scoreboard sb;

	stepper_phase_sequencer dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin : result_monitor
		step_result_t got;
		out_ready <= ($urandom_range(99) >= rcv_idle);
		if (arst_n && out_valid && out_ready) begin
			got.stepped = stepped;
			got.sport = step_port;
			got.duty_a = duty_a;
			got.duty_b = duty_b;
			got.bits = coil_bits;
			got.rem = steps_remaining;
			got.status = cmd_status;
			sb.check_result(got);
		end
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Verification failed");
		$finish;
	end

	function automatic step_req_t make_req(logic [1:0] req, logic p, logic [31:0] now,
			logic [31:0] steps, logic dir, logic [1:0] style);
		step_req_t r;
		r.req = req;
		r.port = p;
		r.now = now;
		r.steps = steps;
		r.dir = dir;
		r.style = style;
		return r;
	endfunction

	// Mostly ticks with the millisecond clock creeping forward; now and then a big jump,
	// a step back or a fresh random time so due-time wrap and resync get exercised.
	function automatic step_req_t random_req(int span, int jump);
		step_req_t r;
		int pick;
		int sel;
		pick = $urandom_range(99);
		if (pick < 70)
			r.req = REQ_TICK;
		else if (pick < 86)
			r.req = REQ_START;
		else if (pick < 95)
			r.req = REQ_STOP;
		else
			r.req = REQ_UNUSED;
		r.port = $urandom_range(1);
		r.dir = $urandom_range(1);
		r.style = $urandom_range(3);
		sel = $urandom_range(9);
		if (sel == 0)
			r.steps = '0;
		else if (sel == 1)
			r.steps = $urandom();
		else if (sel == 2)
			r.steps = '1;
		else
			r.steps = $urandom_range(1, 16);
		sel = $urandom_range(99);
		if (sel < 75)
			cur_ms += $urandom_range(0, span);
		else if (sel < 88)
			cur_ms += $urandom_range(0, jump);
		else if (sel < 95)
			cur_ms -= $urandom_range(0, jump);
		else
			cur_ms = $urandom();
		r.now = cur_ms;
		return r;
	endfunction

	// valid is left high after the transaction; it drops only on an idle gap or a drain
	task automatic send_req(step_req_t r);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < snd_idle);
		end
		in_valid <= 1'b1;
		req_type <= r.req;
		port <= r.port;
		now_ms <= r.now;
		step_count <= r.steps;
		direction <= r.dir;
		step_style <= r.style;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(r);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [15:0] iv0, logic [15:0] iv1, logic [1:0] att);
		write_reg(CFG_IVAL0, iv0);
		write_reg(CFG_IVAL1, iv1);
		write_reg(CFG_ATTACH, {14'($urandom), att});
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int s_idle, int r_idle, int span, int jump);
		int sent;
		step_req_t r;
		snd_idle = s_idle;
		rcv_idle = r_idle;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			r = random_req(span, jump);
			send_req(r);
			if (r.req != REQ_UNUSED)
				sent++;
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing attached, no intervals
		send_req(make_req(REQ_START, 1'b0, 32'd0, 32'd5, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'd0, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_UNUSED, 1'b1, '1, '1, 1'b1, STY_MICRO));
		send_req(make_req(REQ_STOP, 1'b1, 32'd7, 32'd0, 1'b0, STY_DOUBLE));
		drain();
		configure(16'd0, 16'd60000, 2'b01);
		send_req(make_req(REQ_START, 1'b0, 32'd9, 32'd4, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_START, 1'b1, 32'd9, 32'd4, 1'b0, STY_SINGLE));
		drain();
		configure(16'd1, 16'd60000, 2'b11);
		// zero budget is stored but never runs
		send_req(make_req(REQ_START, 1'b0, 32'd100, 32'd0, 1'b0, STY_INTERLEAVE));
		send_req(make_req(REQ_START, 1'b1, 32'd100, 32'd2, 1'b1, STY_MICRO));
		send_req(make_req(REQ_START, 1'b0, 32'd100, 32'd6, 1'b0, STY_SINGLE));
		// tie goes to port 0, then port 1, then catch-up, resync and clock going back
		send_req(make_req(REQ_TICK, 1'b0, 32'd100, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'd100, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'd101, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'd200, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'd150, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'd150, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_STOP, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, STY_SINGLE));
		// full budget, backwards, across the millisecond wrap
		send_req(make_req(REQ_START, 1'b0, 32'hFFFF_FFFE, '1, 1'b1, STY_DOUBLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'hFFFF_FFFE, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_TICK, 1'b0, 32'd0, 32'd0, 1'b0, STY_SINGLE));
		send_req(make_req(REQ_START, 1'b1, 32'd3, 32'd1, 1'b0, STY_INTERLEAVE));
		send_req(make_req(REQ_TICK, 1'b0, 32'd3, 32'd0, 1'b0, STY_SINGLE));
		drain();

		cur_ms = 32'd3;
		configure(16'd3, 16'd5, 2'b11);
		random_phase(28, 58, 6, 40);
		configure(16'd60000, 16'd1, 2'b10);
		random_phase(58, 28, 3, 150000);
		// port 1 attached without an interval; running ports carry on regardless
		write_reg(CFG_ATTACH, 16'd0);
		write_reg(CFG_UNUSED, 16'($urandom));
		configure(16'($urandom_range(1, 40)), 16'd0, 2'b11);
		random_phase(0, 0, 8, 60);

		repeat (4) @(posedge clk);
		$display("Covered %0d requests: %0d steps driven, %0d starts refused, %0d register writes",
			sb.n_requests, sb.n_steps, sb.n_refused, sb.n_writes);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
